FILE: sv/bsm_pkg.sv
// Shared types, sequencer codes and SHA-256 constant tables for the beacon tag unit.
`timescale 1ns / 1ps

package bsm_pkg;

  localparam int WordW   = 32;
  localparam int RndW    = 6;
  localparam int BlockW  = 512;
  localparam int HwIdW   = 40;
  localparam int VendorW = 32;
  localparam int LotW    = 64;
  localparam int StampW  = 64;
  localparam int BattW   = 8;
  localparam int CfgIdxW = 2;

  // Message length in bits (26 bytes), last field of the padded block
  localparam logic [63:0] MSG_BITS = 64'd208;
  localparam logic [RndW-1:0] LAST_ROUND = 6'd63;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_HW_ID  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_VENDOR = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LOT    = 2'd2;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD
  } st_t;

  // Sequencer to round datapath
  typedef struct packed {
    logic            load;
    logic            step;
    logic [RndW-1:0] rnd;
  } core_ctl_t;

  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

FILE: sv/bsm_core.sv
// SHA-256 round datapath: working state, rolling message schedule and digest fold.
`timescale 1ns / 1ps

module bsm_core (
  input  logic                                  clk,
  input  bsm_pkg::core_ctl_t                    ctl,
  input  logic [bsm_pkg::BlockW-1:0]            block,
  output bsm_pkg::word_t                        tag
);

  bsm_pkg::word_t st  [8];
  bsm_pkg::word_t win [16];

  bsm_pkg::word_t t1;
  bsm_pkg::word_t t2;
  bsm_pkg::word_t w_new;
  bsm_pkg::word_t ch;
  bsm_pkg::word_t maj;

  function automatic bsm_pkg::word_t rotr(input bsm_pkg::word_t x, input int n);
    rotr = (x >> n) | (x << (bsm_pkg::WordW - n));
  endfunction

  function automatic bsm_pkg::word_t big_s0(input bsm_pkg::word_t x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic bsm_pkg::word_t big_s1(input bsm_pkg::word_t x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic bsm_pkg::word_t small_s0(input bsm_pkg::word_t x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic bsm_pkg::word_t small_s1(input bsm_pkg::word_t x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // One compression round and the schedule word sixteen rounds ahead
  always_comb begin
    ch    = (st[4] & st[5]) ^ (~st[4] & st[6]);
    maj   = (st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]);
    t1    = st[7] + big_s1(st[4]) + ch + bsm_pkg::K_TAB[ctl.rnd] + win[0];
    t2    = big_s0(st[0]) + maj;
    w_new = win[0] + small_s0(win[1]) + win[9] + small_s1(win[14]);
  end

  // Load the block and initial hash, or advance one round
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < 8; i++) begin
        st[i] <= bsm_pkg::H_INIT[i];
      end
      for (int i = 0; i < 16; i++) begin
        win[i] <= block[bsm_pkg::BlockW-1-bsm_pkg::WordW*i -: bsm_pkg::WordW];
      end
    end else if (ctl.step) begin
      st[7] <= st[6];
      st[6] <= st[5];
      st[5] <= st[4];
      st[4] <= st[3] + t1;
      st[3] <= st[2];
      st[2] <= st[1];
      st[1] <= st[0];
      st[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
    end
  end

  // Add the initial hash back and fold the digest words by XOR
  always_comb begin
    tag = '0;
    for (int j = 0; j < 8; j++) begin
      tag = tag ^ (bsm_pkg::H_INIT[j] + st[j]);
    end
  end

endmodule

FILE: sv/beacon_secure_message_sha256_fold_unit.sv
// Top level of the beacon tag unit: configuration registers, sequencer and result register.
`timescale 1ns / 1ps

// Computes a 32-bit tag for each beat on the s_ side: SHA-256 over the 26-byte
// message {time_stamp, hardware_id, vendor_key, lot_key, battery_level} (all
// most significant byte first, single padded block), with the eight digest
// words XORed together. Each accepted item is loaded into the datapath, runs
// 64 rounds on the single round datapath (one round per cycle), and then a fold
// step writes the result register; the next item is accepted only after that.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the m_ register, and the unit takes the next beat while it waits, but
// holds in the fold step if the previous result is still not taken.
// Configuration writes are always ready and should arrive only while idle.
module beacon_secure_message_sha256_fold_unit (
  input  logic                        clk,
  input  logic                        rst,
  // slave side
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [71:0]                 s_tdata,   // [63:0] time_stamp, [71:64] battery_level
  // master side
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [55:0]                 m_tdata,   // [31:0] auth_tag, [47:32] stamp_low,
                                                 // [55:48] battery_echo
  // configuration write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bsm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]                 cfg_data
);

  logic [bsm_pkg::HwIdW-1:0]   hw_id;
  logic [bsm_pkg::VendorW-1:0] vendor_key;
  logic [bsm_pkg::LotW-1:0]    lot_key;

  bsm_pkg::st_t               state;
  bsm_pkg::st_t               state_next;
  logic [bsm_pkg::RndW-1:0]   rnd;
  logic [bsm_pkg::RndW-1:0]   rnd_next;
  logic [15:0]                stamp_low;
  logic [7:0]                 battery;
  logic                       in_fire;
  logic                       fold_fire;
  bsm_pkg::core_ctl_t         ctl;
  logic [bsm_pkg::BlockW-1:0] block;
  bsm_pkg::word_t             tag;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == bsm_pkg::ST_IDLE);
  assign in_fire   = s_tvalid & s_tready;
  assign fold_fire = (state == bsm_pkg::ST_FOLD) & (~m_tvalid | m_tready);

  // Write configuration registers; unknown indexes drop the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      hw_id      <= '0;
      vendor_key <= '0;
      lot_key    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bsm_pkg::REG_HW_ID:  hw_id      <= cfg_data[bsm_pkg::HwIdW-1:0];
        bsm_pkg::REG_VENDOR: vendor_key <= cfg_data[bsm_pkg::VendorW-1:0];
        bsm_pkg::REG_LOT:    lot_key    <= cfg_data[bsm_pkg::LotW-1:0];
        default: ;
      endcase
    end
  end

  // Assemble the padded message block
  assign block = {s_tdata[bsm_pkg::StampW-1:0], hw_id, vendor_key, lot_key,
                  s_tdata[71:64], 8'h80, 232'd0, bsm_pkg::MSG_BITS};

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsm_pkg::ST_IDLE;
      rnd   <= '0;
    end else begin
      state <= state_next;
      rnd   <= rnd_next;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    ctl.load   = 1'b0;
    ctl.step   = 1'b0;
    ctl.rnd    = rnd;
    unique case (state)
      bsm_pkg::ST_IDLE: begin
        if (in_fire) begin
          ctl.load   = 1'b1;
          rnd_next   = '0;
          state_next = bsm_pkg::ST_ROUND;
        end
      end
      bsm_pkg::ST_ROUND: begin
        ctl.step = 1'b1;
        rnd_next = rnd + 1'b1;
        if (rnd == bsm_pkg::LAST_ROUND) begin
          state_next = bsm_pkg::ST_FOLD;
        end
      end
      bsm_pkg::ST_FOLD: begin
        if (fold_fire) begin
          state_next = bsm_pkg::ST_IDLE;
        end
      end
      default: state_next = bsm_pkg::ST_IDLE;
    endcase
  end

  // Hold the pass-through fields of the item in flight
  always_ff @(posedge clk) begin
    if (in_fire) begin
      stamp_low <= s_tdata[15:0];
      battery   <= s_tdata[71:64];
    end
  end

  bsm_core u_core (
    .clk   (clk),
    .ctl   (ctl),
    .block (block),
    .tag   (tag)
  );

  // Result register: drop on take, load on fold
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (fold_fire) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fold_fire) begin
      m_tdata <= {battery, stamp_low, tag};
    end
  end

`ifndef SYNTH
  a_accept_starts_rounds: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == bsm_pkg::ST_ROUND) && (rnd == '0))
    else $error("accepted beat did not start round zero");

  a_fold_after_all_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == bsm_pkg::ST_FOLD) |-> (rnd == '0))
    else $error("fold reached with round counter not wrapped");

  a_result_from_fold: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == bsm_pkg::ST_FOLD)
    else $error("result raised outside the fold step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !fold_fire)
    else $error("pending result overwritten");
`endif

endmodule

FILE: test/beacon_secure_message_sha256_fold_unit_tb.sv
// Testbench for the beacon tag unit: SHA-256 fold predictor, stream driver and result checker.
`timescale 1ns / 1ps

module beacon_secure_message_sha256_fold_unit_tb;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 80;
  localparam int MaxReports    = 10;
  localparam int RandomItems   = 850;
  localparam int PhaseCount    = 10;

  // Index with no register behind it; the unit must drop the write
  localparam logic [bsm_pkg::CfgIdxW-1:0] REG_UNUSED = 2'd3;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Laid out like m_tdata: battery byte on top, tag in the low bits
  typedef struct packed {
    logic [7:0]  batt;
    logic [15:0] stamp;
    logic [31:0] tag;
  } tag_rec_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [71:0]                  s_tdata = '0;   // [63:0] time_stamp, [71:64] battery_level
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [55:0]                  m_tdata;        // [31:0] auth_tag, [47:32] stamp_low,
                                                // [55:48] battery_echo
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [bsm_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [63:0]                  cfg_data = '0;

  // Shadow copy of the key registers
  logic [bsm_pkg::HwIdW-1:0]    hw_id_key = '0;
  logic [bsm_pkg::VendorW-1:0]  vendor_key = '0;
  logic [bsm_pkg::LotW-1:0]     lot_key = '0;

  tag_rec_t            tags_due [$];
  int unsigned         mismatches = 0;
  int unsigned         beats_sent = 0;
  int unsigned         tags_seen = 0;
  int unsigned         reg_writes = 0;
  int unsigned         key_settings = 0;
  int unsigned         idle_cycles = 0;
  bit                  src_burst = 1'b0;
  bit                  sink_burst = 1'b0;

  beacon_secure_message_sha256_fold_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Hash the 26-byte message in one padded block, then XOR the digest words together
  function automatic logic [31:0] fold_digest(input logic [63:0] stamp, input logic [7:0] batt);
    logic [511:0] blk;
    logic [31:0]  w [64];
    logic [31:0]  st [8];
    logic [31:0]  t1, t2, sg0, sg1, tag;
    int           i;
    blk = {stamp, hw_id_key, vendor_key, lot_key, batt, 8'h80, 232'd0, 64'd208};
    for (i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (i = 16; i < 64; i++) begin
      sg0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      sg1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + sg0 + w[i-7] + sg1;
    end
    for (i = 0; i < 8; i++) st[i] = HASH_IV[i];
    for (i = 0; i < 64; i++) begin
      t1 = st[7] + (ror32(st[4], 6) ^ ror32(st[4], 11) ^ ror32(st[4], 25))
         + ((st[4] & st[5]) ^ (~st[4] & st[6])) + ROUND_K[i] + w[i];
      t2 = (ror32(st[0], 2) ^ ror32(st[0], 13) ^ ror32(st[0], 22))
         + ((st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]));
      st[7] = st[6];
      st[6] = st[5];
      st[5] = st[4];
      st[4] = st[3] + t1;
      st[3] = st[2];
      st[2] = st[1];
      st[1] = st[0];
      st[0] = t1 + t2;
    end
    tag = '0;
    for (i = 0; i < 8; i++) tag ^= HASH_IV[i] + st[i];
    return tag;
  endfunction

  // Send one timestamp/battery beat after a random gap and record its tag
  task automatic send_beat(input logic [63:0] stamp, input logic [7:0] batt);
    int       gap;
    tag_rec_t rec;
    gap = src_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {batt, stamp};
    do @(posedge clk); while (!s_tready);
    rec.batt  = batt;
    rec.stamp = stamp[15:0];
    rec.tag   = fold_digest(stamp, batt);
    tags_due.push_back(rec);
    beats_sent++;
    @(negedge clk);
  endtask

  // Hold until every outstanding tag has come back
  task automatic drain_tags();
    s_tvalid = 1'b0;
    while (tags_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one key register; the shadow keeps only the bits the register holds
  task automatic write_key(input logic [bsm_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bsm_pkg::REG_HW_ID:  hw_id_key  = val[bsm_pkg::HwIdW-1:0];
      bsm_pkg::REG_VENDOR: vendor_key = val[bsm_pkg::VendorW-1:0];
      bsm_pkg::REG_LOT:    lot_key    = val[bsm_pkg::LotW-1:0];
      default:    ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_keys(input logic [63:0] hw, input logic [63:0] vend, input logic [63:0] lot);
    drain_tags();
    write_key(bsm_pkg::REG_HW_ID, hw);
    write_key(bsm_pkg::REG_VENDOR, vend);
    write_key(bsm_pkg::REG_LOT, lot);
    key_settings++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Tags with all keys at their reset value
  task automatic test_reset_keys();
    send_beat(64'h0, 8'h00);
    send_beat(64'hffff_ffff_ffff_ffff, 8'hff);
    send_beat(64'h0123_4567_89ab_cdef, 8'h5a);
    send_beat(64'h8000_0000_0000_0001, 8'h80);
    key_settings++;
  endtask

  // Key extremes, oversize write data and a write to the unused index
  task automatic test_key_extremes();
    set_keys(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_beat(64'h0, 8'h00);
    send_beat(64'hffff_ffff_ffff_ffff, 8'hff);
    set_keys(64'hdead_beef_00a5_5a3c, 64'h1234_5678_8000_0001, 64'h8000_0000_0000_0001);
    send_beat(64'hfedc_ba98_7654_3210, 8'h01);
    drain_tags();
    write_key(REG_UNUSED, 64'hffff_ffff_ffff_ffff);
    send_beat(64'hfedc_ba98_7654_3210, 8'h01);
    send_beat(64'h0000_0000_0000_ffff, 8'hfe);
    set_keys(64'h0, 64'h0, 64'h0);
    send_beat(64'h5555_5555_5555_5555, 8'haa);
    send_beat(64'haaaa_aaaa_aaaa_aaaa, 8'h55);
  endtask

  // Random beats over a series of key settings, with bursts and random gaps
  task automatic test_random_beats();
    int          phase;
    int          k;
    int          pick;
    logic [63:0] stamp;
    logic [7:0]  batt;
    for (phase = 0; phase < PhaseCount; phase++) begin
      pick = $urandom_range(0, 5);
      if (pick == 0)
        set_keys(64'h0, 64'h0, 64'h0);
      else if (pick == 1)
        set_keys(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
      else
        set_keys(rand64(), rand64(), rand64());
      if ($urandom_range(0, 2) == 0) write_key(REG_UNUSED, rand64());
      for (k = 0; k < RandomItems / PhaseCount; k++) begin
        if (k % 16 == 0) src_burst = ($urandom_range(0, 3) == 0);
        pick  = $urandom_range(0, 9);
        stamp = (pick == 0) ? 64'h0 : (pick == 1) ? 64'hffff_ffff_ffff_ffff : rand64();
        pick  = $urandom_range(0, 9);
        batt  = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom());
        send_beat(stamp, batt);
      end
    end
    src_burst = 1'b0;
  endtask

  // Result side: random stall before each beat, with stretches of no stall
  initial begin
    int stall;
    do @(negedge clk); while (rst);
    forever begin
      if (tags_seen % 16 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      stall = sink_burst ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Compare each result beat with the oldest outstanding tag
  always @(posedge clk) begin : check_tags
    tag_rec_t want;
    tag_rec_t got;
    if (!rst && m_tvalid && m_tready) begin
      tags_seen++;
      got = m_tdata;
      if (tags_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result beat: tag %h stamp %h batt %h",
                   got.tag, got.stamp, got.batt);
      end else begin
        want = tags_due.pop_front();
        if (got.tag !== want.tag || got.stamp !== want.stamp || got.batt !== want.batt) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("result %0d: tag exp %h got %h, stamp exp %h got %h, batt exp %h got %h",
                     tags_seen, want.tag, got.tag, want.stamp, got.stamp, want.batt, got.batt);
        end
      end
    end
  end

  // Stop the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_reset_keys();
    test_key_extremes();
    test_random_beats();
    drain_tags();
    repeat (DrainCycles) @(posedge clk);
    if (tags_due.size() != 0) begin
      mismatches++;
      $display("%0d tags never returned", tags_due.size());
    end
    $display("run covered %0d beats and %0d tags over %0d key settings", beats_sent, tags_seen,
             key_settings);
    $display("%0d register writes, %0d mismatches", reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
